// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen at a rising edge of clk.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ----- rtl/topo_pkg.sv -----
// ----------------------------------------------------------------------------
// topo_pkg
// Field widths, reset values and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package topo_pkg;

	localparam int VERT_W = 5;
	localparam int CNT_W  = 6;
	localparam int DATA_W = 16;

	localparam logic [CNT_W-1:0] VCOUNT_RESET = 6'd32;

	typedef struct packed {
		logic load_edge;
		logic eval;
		logic pick;
		logic clear;
	} topo_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_slot;
		logic n_zero;
	} topo_stat_t;

endpackage

`default_nettype wire

// ----- rtl/topo_ctrl.sv -----
// ----------------------------------------------------------------------------
// topo_ctrl
// Sequencer: takes edge beats, then walks the order slots one by one.
// ----------------------------------------------------------------------------
`default_nettype none

module topo_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire                    s_tlast,
	input  topo_pkg::topo_stat_t   stat,
	output topo_pkg::topo_cmd_t    cmd
);
	import topo_pkg::*;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_PICK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.load_edge = accept;
		case (state_q)
			ST_LOAD: begin
				if (accept && s_tlast) begin
					// empty slot count: nothing to emit, just wipe the graph
					if (stat.n_zero) begin
						cmd.clear = 1'b1;
					end else begin
						state_d = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_PICK;
			end
			ST_PICK: begin
				// hold until the result register can take the slot
				if (stat.out_free) begin
					cmd.pick = 1'b1;
					if (stat.last_slot) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						state_d = ST_EVAL;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/topo_dp.sv -----
// ----------------------------------------------------------------------------
// topo_dp
// Datapath: precedence bit matrix, selection marks, ready set, lowest-index
// pick, slot counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module topo_dp #(
	parameter int MAX_VERTICES = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  topo_pkg::topo_cmd_t          cmd,
	output topo_pkg::topo_stat_t         stat,
	input  wire [topo_pkg::VERT_W-1:0]   from_vertex,
	input  wire [topo_pkg::VERT_W-1:0]   to_vertex,
	input  wire                          edge_present,
	input  wire                          cfg_we,
	input  wire [topo_pkg::CNT_W-1:0]    cfg_data,
	input  wire                          m_tready,
	output logic                         m_tvalid,
	output logic [topo_pkg::VERT_W-1:0]  slot_position,
	output logic [topo_pkg::VERT_W-1:0]  vertex_id,
	output logic                         slot_filled,
	output logic                         last_result
);
	import topo_pkg::*;

	// rows and columns beyond the 5-bit vertex fields can never be written
	localparam int NV = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
	localparam int IW = $clog2(NV);
	localparam logic [CNT_W-1:0] NV_C = CNT_W'(NV);

	logic [NV-1:0]     mat_q [NV];
	logic [NV-1:0]     sel_q;
	logic [NV-1:0]     ready_q;
	logic [NV-1:0]     ready_d;
	logic [NV-1:0]     valid_m;
	logic [CNT_W-1:0]  vcount_q;
	logic [CNT_W-1:0]  n_slots;
	logic [VERT_W-1:0] k_q;
	logic [IW-1:0]     pick_idx;
	logic              found;
	logic              edge_ok;
	logic              out_valid_q;
	logic [VERT_W-1:0] pos_q;
	logic [VERT_W-1:0] vid_q;
	logic              filled_q;
	logic              last_q;

	assign n_slots = (vcount_q > NV_C) ? NV_C : vcount_q;
	assign edge_ok = edge_present && ({1'b0, from_vertex} < NV_C)
		&& ({1'b0, to_vertex} < NV_C);

	always_comb begin
		for (int v = 0; v < NV; v++) begin
			valid_m[v] = (CNT_W'(v) < n_slots);
		end
		for (int v = 0; v < NV; v++) begin
			ready_d[v] = !sel_q[v] && valid_m[v]
				&& ((mat_q[v] & valid_m & ~sel_q) == '0);
		end
	end

	// lowest set bit of the ready set
	always_comb begin
		found    = |ready_q;
		pick_idx = '0;
		for (int i = NV - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				pick_idx = IW'(i);
			end
		end
	end

	assign stat.out_free  = !out_valid_q || m_tready;
	assign stat.last_slot = (({1'b0, k_q} + CNT_W'(1)) == n_slots);
	assign stat.n_zero    = (n_slots == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NV; r++) begin
				mat_q[r] <= '0;
			end
			sel_q <= '0;
			k_q   <= '0;
		end else if (cmd.clear) begin
			// clear wins over a same-cycle edge write or pick
			for (int r = 0; r < NV; r++) begin
				mat_q[r] <= '0;
			end
			sel_q <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.load_edge && edge_ok) begin
				mat_q[to_vertex[IW-1:0]][from_vertex[IW-1:0]] <= 1'b1;
			end
			if (cmd.pick) begin
				sel_q <= sel_q | ({{(NV-1){1'b0}}, found} << pick_idx);
				k_q   <= k_q + VERT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			ready_q <= ready_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			pos_q    <= k_q;
			vid_q    <= found ? VERT_W'(pick_idx) : '0;
			filled_q <= found;
			last_q   <= stat.last_slot;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign slot_position = pos_q;
	assign vertex_id     = vid_q;
	assign slot_filled   = filled_q;
	assign last_result   = last_q;

`include "assert_macros.svh"

	`ASSERT_NEVER(a_pick_blocked, cmd.pick && out_valid_q && !m_tready,
		"slot picked while the result register is still occupied")
	`ASSERT_CLK(a_sel_grows,
		cmd.pick && found && !cmd.clear |=>
			$countones(sel_q) == $past($countones(sel_q)) + 1,
		"placed vertex did not add exactly one selection mark")
	`ASSERT_CLK(a_clear_done, cmd.clear |=> (sel_q == '0) && (k_q == '0),
		"selection marks or slot counter not cleared after the run")

endmodule

`default_nettype wire

// ----- rtl/topological_order_lowest_index_top.sv -----
// ----------------------------------------------------------------------------
// topological_order_lowest_index_top
// Lowest-index-first topological sort of an edge-loaded precedence graph.
// ----------------------------------------------------------------------------
// Each input beat carries one optional edge (from -> to, meaning "from comes
// first"); beats are taken while no sort runs. The beat with tlast set also
// runs the sort: input then stalls while the block emits one result beat per
// order slot, each slot in two steps (register the ready set from the
// precedence matrix, then the lowest-index pick into the result register,
// which waits while the result side stalls). A slot with no ready vertex (a
// cycle in the graph) comes out unfilled, and so do the rest. The matrix and
// selection marks are wiped in the cycle that loads the final slot, so no
// clearing pass follows reset or a run. Write vertex_count only while no run
// is in progress.
`default_nettype none

module topological_order_lowest_index_top #(
	parameter int MAX_VERTICES = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// s_tdata: from_vertex[4:0], to_vertex[9:5], zero fill [15:10]
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [topo_pkg::DATA_W-1:0]    s_tdata,
	// s_tuser: edge_present[0]
	input  wire [0:0]                     s_tuser,
	input  wire                           s_tlast,
	// m_tdata: slot_position[4:0], vertex_id[9:5], zero fill [15:10]
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [topo_pkg::DATA_W-1:0]   m_tdata,
	// m_tuser: slot_filled[0]
	output logic [0:0]                    m_tuser,
	output logic                          m_tlast,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [topo_pkg::CNT_W-1:0]     cfg_data
);
	import topo_pkg::*;

	topo_cmd_t         cmd;
	topo_stat_t        stat;
	logic [VERT_W-1:0] slot_position;
	logic [VERT_W-1:0] vertex_id;

	assign cfg_ready = 1'b1;

	topo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.cmd      (cmd)
	);

	topo_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.from_vertex   (s_tdata[VERT_W-1:0]),
		.to_vertex     (s_tdata[2*VERT_W-1:VERT_W]),
		.edge_present  (s_tuser[0]),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.slot_position (slot_position),
		.vertex_id     (vertex_id),
		.slot_filled   (m_tuser[0]),
		.last_result   (m_tlast)
	);

	assign m_tdata = {{(DATA_W-2*VERT_W){1'b0}}, vertex_id, slot_position};

endmodule

`default_nettype wire

// ----- bench/topological_order_lowest_index_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topological_order_lowest_index_top_tb
// Loads precedence graphs edge by edge and checks every emitted order slot
// against an in-bench lowest-index-first sort. Both stream sides idle at
// random, and vertex_count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module topological_order_lowest_index_top_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP     = 14;
	localparam int SETTLE      = 8;

	typedef struct packed {
		logic [4:0] slot;
		logic [4:0] vertex;
		logic       filled;
		logic       is_last;
	} order_slot_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [topo_pkg::DATA_W-1:0]    s_tdata = '0;
	logic [0:0]                     s_tuser = '0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [topo_pkg::DATA_W-1:0]    m_tdata;
	logic [0:0]                     m_tuser;
	logic                           m_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [topo_pkg::CNT_W-1:0]     cfg_data = '0;

	// precedence matrix copy: bit f of row t set when edge f -> t is loaded
	logic [31:0]                    pred_rows [32];
	logic [topo_pkg::CNT_W-1:0]     pred_count = topo_pkg::VCOUNT_RESET;
	order_slot_t                    expected_slots [$];
	int                             fail_count = 0;
	int                             cycle_count = 0;
	int                             ready_hold = 0;
	bit                             idle_on = 1'b1;

	topological_order_lowest_index_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[topological_order_lowest_index_top] ERROR");
			$finish;
		end
	end

	// Add the beat's edge, and on the final beat queue the slots of the sort.
	function automatic void rank_vertices(input logic [4:0] from_v, input logic [4:0] to_v,
			input logic edge_on, input logic fin);
		int          n;
		int          pick;
		logic [31:0] live;
		logic [31:0] sel;
		logic        stuck;
		logic        found;
		order_slot_t s;
		if (edge_on)
			pred_rows[to_v][from_v] = 1'b1;
		if (!fin)
			return;
		n = (pred_count > 32) ? 32 : int'(pred_count);
		live = (n == 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
		sel = '0;
		stuck = 1'b0;
		for (int k = 0; k < n; k++) begin
			found = 1'b0;
			pick = 0;
			if (!stuck) begin
				for (int v = 0; v < n && !found; v++) begin
					if (!sel[v] && (pred_rows[v] & live & ~sel) == 32'h0) begin
						pick = v;
						found = 1'b1;
					end
				end
				if (found)
					sel[pick] = 1'b1;
				else
					stuck = 1'b1;
			end
			s.slot    = 5'(k);
			s.vertex  = found ? 5'(pick) : 5'd0;
			s.filled  = found;
			s.is_last = (k == n - 1);
			expected_slots.push_back(s);
		end
		for (int r = 0; r < 32; r++)
			pred_rows[r] = '0;
	endfunction

	// Result side: random stalls, compare each beat with the oldest slot.
	always @(posedge clk) begin
		order_slot_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_slots.size() == 0) begin
				$error("unexpected result beat: m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_slots.pop_front();
				if (m_tdata[4:0] !== want.slot) begin
					$error("slot_position: expected %0d, got %0d", want.slot, m_tdata[4:0]);
					fail_count++;
				end
				if (m_tdata[9:5] !== want.vertex) begin
					$error("vertex_id: expected %0d, got %0d", want.vertex, m_tdata[9:5]);
					fail_count++;
				end
				if (m_tuser[0] !== want.filled) begin
					$error("slot_filled: expected %0d, got %0d", want.filled, m_tuser[0]);
					fail_count++;
				end
				if (m_tlast !== want.is_last) begin
					$error("last_result: expected %0d, got %0d", want.is_last, m_tlast);
					fail_count++;
				end
			end
			ready_hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end
		m_tready <= (ready_hold == 0);
	end

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_edge(input logic [4:0] from_v, input logic [4:0] to_v,
			input logic edge_on, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, to_v, from_v};
		s_tuser  <= edge_on;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		rank_vertices(from_v, to_v, edge_on, fin);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_slots.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_vertex_count(input logic [topo_pkg::CNT_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pred_count = value;
	endtask

	// Reset count of 32; an edge flagged absent must not load.
	task automatic test_reset_count();
		send_edge(5'd31, 5'd0, 1'b1, 1'b0);
		send_edge(5'd5, 5'd3, 1'b0, 1'b0);
		send_edge(5'd0, 5'd1, 1'b1, 1'b1);
	endtask

	task automatic test_single_vertex();
		write_vertex_count(6'd1);
		send_edge(5'd0, 5'd0, 1'b0, 1'b1);
		send_edge(5'd0, 5'd0, 1'b1, 1'b1);
		send_edge(5'd31, 5'd0, 1'b1, 1'b1);
	endtask

	// Chain 2 -> 1 -> 3 -> 0 with a duplicate, out-of-range ends and an edge on tlast.
	task automatic test_chain_and_range();
		write_vertex_count(6'd4);
		send_edge(5'd3, 5'd0, 1'b1, 1'b0);
		send_edge(5'd3, 5'd0, 1'b1, 1'b0);
		send_edge(5'd2, 5'd1, 1'b1, 1'b0);
		send_edge(5'd9, 5'd2, 1'b1, 1'b0);
		send_edge(5'd0, 5'd31, 1'b1, 1'b0);
		send_edge(5'd1, 5'd3, 1'b1, 1'b1);
	endtask

	task automatic test_cycle();
		write_vertex_count(6'd3);
		send_edge(5'd0, 5'd1, 1'b1, 1'b0);
		send_edge(5'd1, 5'd0, 1'b1, 1'b0);
		send_edge(5'd2, 5'd2, 1'b0, 1'b1);
		write_vertex_count(6'd32);
		send_edge(5'd31, 5'd31, 1'b1, 1'b0);
		send_edge(5'd30, 5'd29, 1'b1, 1'b0);
		send_edge(5'd0, 5'd0, 1'b0, 1'b1);
	endtask

	function automatic logic [4:0] pick_vertex(input int n);
		if ($urandom_range(0, 99) < 85)
			return 5'($urandom_range(0, n - 1));
		return 5'($urandom_range(0, 31));
	endfunction

	// Mostly acyclic graphs by a random ranking, some random graphs, some noise.
	task automatic test_random_graphs();
		int          rank_of [32];
		int          n;
		int          len;
		int          style;
		int          phase_sent;
		int          j;
		int          tmp;
		logic [4:0]  a;
		logic [4:0]  b;
		logic [4:0]  t;
		logic        edge_on;
		logic [5:0]  counts [6];
		counts = '{6'd32, 6'd1, 6'($urandom_range(2, 31)), 6'd8, 6'd32,
			6'($urandom_range(1, 32))};
		for (int p = 0; p < 6; p++) begin
			write_vertex_count(counts[p]);
			n = int'(counts[p]);
			phase_sent = 0;
			while (phase_sent < 36) begin
				for (int i = 0; i < 32; i++)
					rank_of[i] = i;
				for (int i = 31; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = rank_of[i];
					rank_of[i] = rank_of[j];
					rank_of[j] = tmp;
				end
				idle_on = (p != 3) && ($urandom_range(0, 5) != 0);
				style = $urandom_range(0, 9);
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					a = pick_vertex(n);
					b = pick_vertex(n);
					if (style < 7 && rank_of[a] > rank_of[b]) begin
						t = a;
						a = b;
						b = t;
					end
					edge_on = (style == 9) ? 1'($urandom_range(0, 1))
						: ($urandom_range(0, 7) != 0);
					send_edge(a, b, edge_on, i == len - 1);
				end
				phase_sent += len;
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int r = 0; r < 32; r++)
			pred_rows[r] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_single_vertex();
		test_chain_and_range();
		test_cycle();
		test_random_graphs();
		drain_results();
		if (fail_count == 0) begin
			$display("[topological_order_lowest_index_top] OK");
		end else begin
			$display("[topological_order_lowest_index_top] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/topo_pkg.sv
rtl/topo_ctrl.sv
rtl/topo_dp.sv
rtl/topological_order_lowest_index_top.sv
bench/topological_order_lowest_index_top_tb.sv
